>>> rtl/core/monf_pkg.sv
// Shared widths, codes and the result word type of the overlap note filter.
package monf_pkg;

	// Field widths of the event words.
	localparam int KIND_W  = 2;
	localparam int CH_W    = 4;
	localparam int PITCH_W = 7;
	localparam int POS_W   = 32;
	localparam int TAG_W   = 16;

	// Width of the flat (channel, pitch) index before it is cut to the address.
	localparam int IDX_W = CH_W + PITCH_W;

	// Defaults of the top-level parameters.
	localparam int CHANNELS_DEF    = 16;
	localparam int PITCHES_DEF     = 128;
	localparam int COUNT_WIDTH_DEF = 8;

	// Result queue between the update stage and the output channel.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;

	// Event kind codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_OFF = 2'd1,
		KIND_OTHER    = 2'd2
	} kind_t;

	// Overlap handling modes.
	typedef enum logic [1:0] {
		MODE_TRIM   = 2'd0,
		MODE_MERGE  = 2'd1,
		MODE_IGNORE = 2'd2,
		MODE_ERROR  = 2'd3
	} mode_t;

	// One result word as it waits in the output queue.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CH_W-1:0]    channel;
		logic [PITCH_W-1:0] pitch;
		logic [POS_W-1:0]   position;
		logic [TAG_W-1:0]   tag;
		logic               synthesized;
		logic               overlap_error;
		logic               last;
	} result_t;

endpackage

>>> rtl/core/monf_if.sv
// Valid/ready channel interfaces for the input events and the filtered results.
interface monf_in_if;
	import monf_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  event_kind;
	logic [CH_W-1:0]    channel;
	logic [PITCH_W-1:0] pitch;
	logic [POS_W-1:0]   position;
	logic [TAG_W-1:0]   event_tag;

	modport source (output valid, event_kind, channel, pitch, position, event_tag,
		input ready);
	modport sink (input valid, event_kind, channel, pitch, position, event_tag,
		output ready);
endinterface

interface monf_out_if;
	import monf_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  out_kind;
	logic [CH_W-1:0]    out_channel;
	logic [PITCH_W-1:0] out_pitch;
	logic [POS_W-1:0]   out_position;
	logic [TAG_W-1:0]   out_tag;
	logic               synthesized;
	logic               overlap_error;
	logic               last;

	modport source (output valid, out_kind, out_channel, out_pitch, out_position,
		out_tag, synthesized, overlap_error, last, input ready);
	modport sink (input valid, out_kind, out_channel, out_pitch, out_position,
		out_tag, synthesized, overlap_error, last, output ready);
endinterface

>>> rtl/core/midi_overlap_note_filter.sv
// Overlap note filter: active-note counter memory, update stage and result queue.
//
// Usage: event words enter on events (valid/ready) and filtered words leave on
// results (valid/ready). Each input word yields zero, one or two output words;
// the last output word of an input carries last = 1. cfg_we/cfg_wdata write the
// overlap mode and should be written only while no word is in flight.
// Throughput: one input word per cycle while events.ready is high. The counter
// memory is read when a word is accepted and written back in the next cycle;
// the write of the previous word is forwarded, so a word may follow on the same
// note in the next cycle. A result is written into the output queue in the
// cycle after its input is accepted and leaves on results from the queue head.
// Reset: arst_n clears the control state and starts a clearing pass that zeros
// the CHANNELS*PITCHES counters, one per cycle; no input word is accepted until
// it is done, configuration writes are taken.
// Stalls: results wait in an eight-word queue; events.ready drops when the
// queue could not take the two words of one more input.
module midi_overlap_note_filter #(
	parameter int CHANNELS    = monf_pkg::CHANNELS_DEF,
	parameter int PITCHES     = monf_pkg::PITCHES_DEF,
	parameter int COUNT_WIDTH = monf_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	monf_in_if.sink    events,
	monf_out_if.source results
);
	import monf_pkg::*;

	localparam int DEPTH  = CHANNELS * PITCHES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [FIFO_CW:0]  FILL_LIMIT = (FIFO_CW+1)'(FIFO_DEPTH - 2);

	// Configuration and sticky error.
	mode_t mode_q;
	logic  err_q;

	// Counter memory and its clearing pass.
	logic signed [COUNT_WIDTH-1:0] mem [DEPTH];
	logic                          clearing_q;
	logic [ADDR_W-1:0]             clr_addr_q;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_wa;
	logic signed [COUNT_WIDTH-1:0] mem_wd;

	// Last memory write, forwarded to the update stage.
	logic                          fwd_valid_q;
	logic [ADDR_W-1:0]             fwd_addr_q;
	logic signed [COUNT_WIDTH-1:0] fwd_data_q;

	// Update stage.
	logic                          valid_s1;
	logic [KIND_W-1:0]             kind_s1;
	logic [CH_W-1:0]               ch_s1;
	logic [PITCH_W-1:0]            pitch_s1;
	logic [POS_W-1:0]              pos_s1;
	logic [TAG_W-1:0]              tag_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic                          inrange_s1;
	logic signed [COUNT_WIDTH-1:0] rd_data_s1;

	// Result queue.
	result_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_CW-1:0] cnt_q;

	logic                          in_acc;
	logic                          out_pop;
	logic [IDX_W-1:0]              idx_full;
	logic                          in_range;
	logic signed [COUNT_WIDTH-1:0] cnt_cur;
	logic signed [COUNT_WIDTH-1:0] cnt_inc;
	logic signed [COUNT_WIDTH-1:0] cnt_dec;
	logic                          upd_we;
	logic signed [COUNT_WIDTH-1:0] upd_wd;
	logic                          err_set;
	logic [1:0]                    push_n;
	result_t                       res0;
	result_t                       res1;

	// Handshakes.
	assign in_acc  = events.valid && events.ready;
	assign out_pop = results.valid && results.ready;
	assign events.ready = !clearing_q &&
		(({1'b0, cnt_q} + (valid_s1 ? (FIFO_CW+1)'(2) : '0)) <= FILL_LIMIT);

	// Flat note address and range check of the incoming word.
	assign idx_full = IDX_W'(events.channel) * IDX_W'(PITCHES) + IDX_W'(events.pitch);
	assign in_range = ({1'b0, events.channel} < (CH_W+1)'(CHANNELS)) &&
		({1'b0, events.pitch} < (PITCH_W+1)'(PITCHES));

	// Mode register and sticky error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TRIM;
			err_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_wdata);
			end
			if (err_set) begin
				err_q <= 1'b1;
			end
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Memory write port: clearing pass or write-back of the update stage.
	assign mem_we = clearing_q || upd_we;
	assign mem_wa = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wd = clearing_q ? '0 : upd_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Registered read at acceptance.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_data_s1 <= mem[idx_full[ADDR_W-1:0]];
		end
	end

	// Forwarding register of the most recent write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= mem_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= mem_wa;
		fwd_data_q <= mem_wd;
	end

	// Update stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1    <= events.event_kind;
			ch_s1      <= events.channel;
			pitch_s1   <= events.pitch;
			pos_s1     <= events.position;
			tag_s1     <= events.event_tag;
			addr_s1    <= idx_full[ADDR_W-1:0];
			inrange_s1 <= in_range;
		end
	end

	// Current counter with the previous write forwarded, and its saturated steps.
	assign cnt_cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data_s1;
	assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
	assign cnt_dec = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_cur - COUNT_WIDTH'(1);

	// Filter rules: results, counter write-back and error detection.
	always_comb begin
		upd_we  = 1'b0;
		upd_wd  = cnt_inc;
		err_set = 1'b0;
		push_n  = 2'd0;
		res0    = '0;
		res1    = '0;
		res0.channel  = ch_s1;
		res0.pitch    = pitch_s1;
		res0.position = pos_s1;
		res0.tag      = tag_s1;
		res0.kind     = kind_s1;
		res1          = res0;
		if (valid_s1 && !err_q) begin
			if (kind_s1 != KIND_NOTE_ON && kind_s1 != KIND_NOTE_OFF) begin
				// Other events pass with a zero note address.
				res0.kind    = KIND_OTHER;
				res0.channel = '0;
				res0.pitch   = '0;
				push_n       = 2'd1;
			end else if (mode_q == MODE_IGNORE || !inrange_s1) begin
				push_n = 2'd1;
			end else if (kind_s1 == KIND_NOTE_ON) begin
				if (mode_q == MODE_ERROR && cnt_cur != '0) begin
					// Overlap in error mode: report it and stop the stream.
					err_set             = 1'b1;
					res0.overlap_error  = 1'b1;
					push_n              = 2'd1;
				end else begin
					upd_we = 1'b1;
					upd_wd = cnt_inc;
					if (cnt_cur != '0 && mode_q == MODE_TRIM) begin
						// Close the sounding note before the new note-on.
						res0.kind        = KIND_NOTE_OFF;
						res0.tag         = '0;
						res0.synthesized = 1'b1;
						push_n           = 2'd2;
					end else if (cnt_cur == '0) begin
						push_n = 2'd1;
					end
				end
			end else begin
				// Note-off passes when the note is released, or always in error mode.
				upd_we = 1'b1;
				upd_wd = cnt_dec;
				if (mode_q == MODE_ERROR || cnt_dec == '0) begin
					push_n = 2'd1;
				end
			end
		end
		res0.last = (push_n == 2'd1);
		res1.last = 1'b1;
	end

	// Result queue.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wp_q] <= res0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wp_q + FIFO_AW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(push_n);
			rp_q  <= rp_q + FIFO_AW'(out_pop);
			cnt_q <= cnt_q + FIFO_CW'(push_n) - FIFO_CW'(out_pop);
		end
	end

	// Output channel driven from the queue head.
	assign results.valid         = (cnt_q != '0);
	assign results.out_kind      = fifo_q[rp_q].kind;
	assign results.out_channel   = fifo_q[rp_q].channel;
	assign results.out_pitch     = fifo_q[rp_q].pitch;
	assign results.out_position  = fifo_q[rp_q].position;
	assign results.out_tag       = fifo_q[rp_q].tag;
	assign results.synthesized   = fifo_q[rp_q].synthesized;
	assign results.overlap_error = fifo_q[rp_q].overlap_error;
	assign results.last          = fifo_q[rp_q].last;

endmodule

>>> tb/monf_checker.sv
// Checker of the overlap note filter: predicts every result word and compares it.
module monf_checker #(
	parameter int CHANNELS    = monf_pkg::CHANNELS_DEF,
	parameter int PITCHES     = monf_pkg::PITCHES_DEF,
	parameter int COUNT_WIDTH = monf_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	monf_in_if         events,
	monf_out_if        results,
	output int         fail_count,
	output int         pending
);
	import monf_pkg::*;

	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	// Own copy of the active-note counters, the sticky error and the mode.
	logic signed [COUNT_WIDTH-1:0] note_count [CHANNELS*PITCHES];
	logic                          overlap_latched;
	mode_t                         filter_mode;
	result_t                       expected_words [$];

	// Appends one predicted word at the tail of the queue.
	function automatic void append_word(input result_t word);
		expected_words.insert(expected_words.size(), word);
	endfunction

	// Works out the words that one accepted event causes and queues them.
	function automatic void apply_overlap_rule(input logic [KIND_W-1:0] kind,
			input logic [CH_W-1:0] ch, input logic [PITCH_W-1:0] pitch,
			input logic [POS_W-1:0] pos, input logic [TAG_W-1:0] tag);
		result_t                       word;
		result_t                       closing;
		int                            first;
		int                            idx;
		logic signed [COUNT_WIDTH-1:0] cnt;
		logic signed [COUNT_WIDTH-1:0] next_cnt;

		if (overlap_latched) begin
			return;
		end
		first = expected_words.size();
		word = '0;
		word.kind = kind;
		word.channel = ch;
		word.pitch = pitch;
		word.position = pos;
		word.tag = tag;

		if (kind != KIND_NOTE_ON && kind != KIND_NOTE_OFF) begin
			// Anything that is not a note passes with a cleared note address.
			word.kind = KIND_OTHER;
			word.channel = '0;
			word.pitch = '0;
			append_word(word);
		end else if (filter_mode == MODE_IGNORE || ch >= CHANNELS || pitch >= PITCHES) begin
			append_word(word);
		end else begin
			idx = ch * PITCHES + pitch;
			cnt = note_count[idx];
			if (kind == KIND_NOTE_ON) begin
				if (filter_mode == MODE_ERROR && cnt != 0) begin
					// The overlap is reported once and blocks everything after it.
					overlap_latched = 1'b1;
					word.overlap_error = 1'b1;
					append_word(word);
				end else begin
					note_count[idx] = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
					if (cnt != 0 && filter_mode == MODE_TRIM) begin
						// Trim closes the sounding note at the same position first.
						closing = word;
						closing.kind = KIND_NOTE_OFF;
						closing.tag = '0;
						closing.synthesized = 1'b1;
						append_word(closing);
					end
					if (cnt == 0 || filter_mode == MODE_TRIM) begin
						append_word(word);
					end
				end
			end else begin
				next_cnt = (cnt == COUNT_MIN) ? cnt : cnt - COUNT_WIDTH'(1);
				note_count[idx] = next_cnt;
				if (filter_mode == MODE_ERROR || next_cnt == 0) begin
					append_word(word);
				end
			end
		end

		// Mark the final word of this event.
		if (expected_words.size() > first) begin
			expected_words[expected_words.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic check_field(input string field, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t got;
		result_t want;

		if (!arst_n) begin
			for (int i = 0; i < CHANNELS * PITCHES; i++) begin
				note_count[i] = '0;
			end
			overlap_latched = 1'b0;
			filter_mode = MODE_TRIM;
			expected_words.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// Predict the words caused by an accepted input word.
			if (events.valid && events.ready) begin
				apply_overlap_rule(events.event_kind, events.channel, events.pitch,
					events.position, events.event_tag);
			end

			// Compare an accepted result word with the oldest prediction.
			if (results.valid && results.ready) begin
				got.kind = results.out_kind;
				got.channel = results.out_channel;
				got.pitch = results.out_pitch;
				got.position = results.out_position;
				got.tag = results.out_tag;
				got.synthesized = results.synthesized;
				got.overlap_error = results.overlap_error;
				got.last = results.last;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, got);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("kind", POS_W'(want.kind), POS_W'(got.kind));
					check_field("channel", POS_W'(want.channel), POS_W'(got.channel));
					check_field("pitch", POS_W'(want.pitch), POS_W'(got.pitch));
					check_field("position", want.position, got.position);
					check_field("tag", POS_W'(want.tag), POS_W'(got.tag));
					check_field("synthesized", POS_W'(want.synthesized),
						POS_W'(got.synthesized));
					check_field("overlap_error", POS_W'(want.overlap_error),
						POS_W'(got.overlap_error));
					check_field("last", POS_W'(want.last), POS_W'(got.last));
				end
			end

			// A mode write takes effect for the words that follow it.
			if (cfg_we) begin
				filter_mode = mode_t'(cfg_wdata);
			end
			pending <= expected_words.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the overlap note filter testbench: clock, reset, stimulus and verdict.
module testbench;
	import monf_pkg::*;

	localparam int                HALF_PERIOD   = 6;
	localparam int                RESET_CYCLES  = 8;
	localparam int                SETTLE_CYCLES = 8;
	localparam int                LONG_HOLD     = 160;
	localparam int                RUN_LIMIT     = 12 * 500000;
	localparam int                HOT_NOTES     = 8;
	localparam int                SAT_RUN       = 132;
	localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

	typedef enum int {RX_STEADY, RX_HALF, RX_LIGHT, RX_HEAVY} rx_pattern_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_wdata;
	logic             long_hold_req;
	int               fail_count;
	int               pending;
	int               burst_left;
	logic [IDX_W-1:0] hot_notes [HOT_NOTES];
	bit               note_used [2**IDX_W];

	monf_in_if  in_bus ();
	monf_out_if out_bus ();

	midi_overlap_note_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.events    (in_bus),
		.results   (out_bus)
	);

	monf_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.events     (in_bus),
		.results    (out_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Hard stop in case the block hangs.
	initial begin
		#RUN_LIMIT;
		$display("Some tests failed");
		$finish;
	end

	// Result receiver: random stall patterns and one long hold-off on request.
	initial begin : receiver
		rx_pattern_t pattern;
		int          pattern_left;
		int          hold_left;
		bit          hold_done;
		logic        rdy;

		pattern = RX_STEADY;
		pattern_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		out_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern = rx_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(4, 60);
				end
				pattern_left--;
				case (pattern)
					RX_STEADY: rdy = 1'b1;
					RX_HALF: rdy = ($urandom_range(0, 1) != 0);
					RX_LIGHT: rdy = ($urandom_range(0, 4) != 0);
					default: rdy = ($urandom_range(0, 4) == 0);
				endcase
			end
			out_bus.ready <= rdy;
		end
	end

	// Offers one word and returns at the edge that accepts it.
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
			input logic [PITCH_W-1:0] pitch, input logic [POS_W-1:0] pos,
			input logic [TAG_W-1:0] tag);
		int gap;

		// A new burst may start after a gap.
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_bus.valid <= 1'b1;
		in_bus.event_kind <= kind;
		in_bus.channel <= ch;
		in_bus.pitch <= pitch;
		in_bus.position <= pos;
		in_bus.event_tag <= tag;
		@(posedge clk);
		while (in_bus.ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	// Stops offering and waits until every predicted word has come out.
	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input mode_t mode);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Note address from the busy set most of the time, else anywhere.
	function automatic logic [IDX_W-1:0] any_note();
		if ($urandom_range(0, 9) < 7) begin
			return hot_notes[$urandom_range(0, HOT_NOTES - 1)];
		end
		return IDX_W'($urandom_range(0, 2**IDX_W - 1));
	endfunction

	// Note address that no note event has touched so far.
	function automatic logic [IDX_W-1:0] fresh_note();
		logic [IDX_W-1:0] note;

		do begin
			note = IDX_W'($urandom_range(0, 2**IDX_W - 1));
		end while (note_used[note]);
		return note;
	endfunction

	task automatic send_note(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] note);
		note_used[note] = 1'b1;
		send_word(kind, note[IDX_W-1:PITCH_W], note[PITCH_W-1:0], $urandom,
			TAG_W'($urandom_range(0, 16'hFFFF)));
	endtask

	// One random event; note-ons go to untouched notes when overlaps must be avoided.
	task automatic send_random_item(input bit fresh_onsets);
		int               pick;
		logic [IDX_W-1:0] note;

		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			note = fresh_onsets ? fresh_note() : any_note();
			send_note(KIND_NOTE_ON, note);
		end else if (pick < 80) begin
			send_note(KIND_NOTE_OFF, any_note());
		end else begin
			send_word((pick < 93) ? KIND_OTHER : KIND_UNUSED, CH_W'($urandom_range(0, 15)),
				PITCH_W'($urandom_range(0, 127)), $urandom,
				TAG_W'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	task automatic run_random_phase(input mode_t mode, input int count, input bit pressure);
		write_mode(mode);
		if (pressure) begin
			long_hold_req <= 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			// Midway the sender pauses until the output side has caught up.
			if (pressure && i == count / 2) begin
				wait_drained();
			end
			send_random_item(1'b0);
		end
	endtask

	initial begin : stimulus
		logic [IDX_W-1:0] sat_note;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_TRIM;
		long_hold_req <= 1'b0;
		in_bus.valid <= 1'b0;
		in_bus.event_kind <= KIND_NOTE_ON;
		in_bus.channel <= '0;
		in_bus.pitch <= '0;
		in_bus.position <= '0;
		in_bus.event_tag <= '0;
		burst_left = 0;

		// Busy notes include both corners of the address space.
		hot_notes[0] = '0;
		hot_notes[1] = '1;
		for (int i = 2; i < HOT_NOTES; i++) begin
			hot_notes[i] = IDX_W'($urandom_range(0, 2**IDX_W - 1));
		end
		for (int i = 0; i < HOT_NOTES; i++) begin
			note_used[hot_notes[i]] = 1'b1;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Trim: repeated note-on, partial and final note-off, other events.
		write_mode(MODE_TRIM);
		send_word(KIND_NOTE_ON, 4'd0, 7'd0, 32'd0, 16'd0);
		send_word(KIND_NOTE_ON, 4'd0, 7'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(KIND_NOTE_OFF, 4'd0, 7'd0, 32'd100, 16'd3);
		send_word(KIND_NOTE_OFF, 4'd0, 7'd0, 32'd101, 16'd4);
		send_word(KIND_OTHER, 4'd15, 7'd127, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(KIND_UNUSED, 4'd5, 7'd42, 32'd7, 16'd9);
		send_word(KIND_NOTE_ON, 4'd15, 7'd127, 32'hFFFF_FFFF, 16'd1);
		send_word(KIND_NOTE_ON, 4'd15, 7'd127, 32'd0, 16'hFFFF);
		send_word(KIND_NOTE_OFF, 4'd15, 7'd127, 32'd5, 16'd2);
		send_word(KIND_NOTE_OFF, 4'd15, 7'd127, 32'd6, 16'd3);
		send_word(KIND_NOTE_OFF, 4'd0, 7'd0, 32'd8, 16'd4);

		// Merge, starting from the negative count left above.
		write_mode(MODE_MERGE);
		send_word(KIND_NOTE_ON, 4'd0, 7'd0, 32'd10, 16'd10);
		send_word(KIND_NOTE_ON, 4'd0, 7'd0, 32'd11, 16'd11);
		send_word(KIND_NOTE_ON, 4'd0, 7'd0, 32'd12, 16'd12);
		send_word(KIND_NOTE_OFF, 4'd0, 7'd0, 32'd13, 16'd13);
		send_word(KIND_NOTE_OFF, 4'd0, 7'd0, 32'd14, 16'd14);

		// Ignore passes everything and leaves the counters alone.
		write_mode(MODE_IGNORE);
		send_word(KIND_NOTE_ON, 4'd15, 7'd127, 32'd20, 16'd20);
		send_word(KIND_NOTE_ON, 4'd15, 7'd127, 32'd21, 16'd21);
		send_word(KIND_NOTE_OFF, 4'd15, 7'd127, 32'd22, 16'd22);
		send_word(KIND_NOTE_OFF, 4'd15, 7'd127, 32'd23, 16'd23);
		send_word(KIND_NOTE_OFF, 4'd0, 7'd0, 32'd24, 16'd24);

		// Random traffic on busy notes through the non-latching modes.
		run_random_phase(MODE_TRIM, 80, 1'b1);
		run_random_phase(MODE_MERGE, 80, 1'b0);
		run_random_phase(MODE_IGNORE, 60, 1'b0);
		run_random_phase(MODE_TRIM, 80, 1'b0);
		run_random_phase(MODE_MERGE, 80, 1'b0);

		// Drive one counter past its upper limit, another past its lower one.
		write_mode(MODE_TRIM);
		sat_note = fresh_note();
		repeat (SAT_RUN) send_note(KIND_NOTE_ON, sat_note);
		send_note(KIND_NOTE_OFF, sat_note);
		write_mode(MODE_MERGE);
		sat_note = fresh_note();
		repeat (SAT_RUN) send_note(KIND_NOTE_OFF, sat_note);
		send_note(KIND_NOTE_ON, sat_note);

		// Error mode: clean traffic first, then one overlap that latches the error.
		write_mode(MODE_ERROR);
		repeat (60) send_random_item(1'b1);
		sat_note = fresh_note();
		send_note(KIND_NOTE_ON, sat_note);
		send_note(KIND_NOTE_ON, sat_note);
		repeat (10) send_random_item(1'b0);

		// The latched error keeps blocking after a mode change.
		write_mode(MODE_TRIM);
		repeat (10) send_random_item(1'b0);

		wait_drained();
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/monf_pkg.sv
rtl/core/monf_if.sv
rtl/core/midi_overlap_note_filter.sv
tb/monf_checker.sv
tb/testbench.sv
